@@ design/pfd_pkg.sv @@
// Package for the PDO frame demapper: table sizing, item kinds and the
// mapping entry layout. No dependencies.
package pfd_pkg;

    localparam int MAX_MAPPINGS = 8;
    localparam int MAP_AW       = (MAX_MAPPINGS > 1) ? $clog2(MAX_MAPPINGS) : 1;
    localparam int CNT_W        = $clog2(MAX_MAPPINGS + 1);
    localparam int MAX_BIT_LEN  = 32;
    localparam int FRAME_BYTES  = 8;
    localparam int VALUE_W      = 32;
    localparam int OFFSET_W     = 7;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_FRAME = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef struct packed {
        logic [15:0] object_index;
        logic [7:0]  sub_index;
        logic [5:0]  bit_length;
    } t_map_entry;

    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] addr;
        t_map_entry        entry;
    } t_map_wr;

    typedef struct packed {
        logic               we;
        logic [MAP_AW-1:0]  addr;
        logic [VALUE_W-1:0] value;
    } t_val_wr;

endpackage

@@ design/pfd_map_ram.sv @@
// Mapping table memory: one write port, one registered read port.
// Depends on pfd_pkg. Contents are undefined until written.
module pfd_map_ram (
    input  logic                       i_clk,
    input  pfd_pkg::t_map_wr           i_wr,
    input  logic [pfd_pkg::MAP_AW-1:0] i_raddr,
    output pfd_pkg::t_map_entry        o_rdata
);

    pfd_pkg::t_map_entry r_mem [pfd_pkg::MAX_MAPPINGS];
    pfd_pkg::t_map_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/pfd_value_ram.sv @@
// Unpacked value memory with per-entry valid bits so that never-written
// entries read as zero after reset. Depends on pfd_pkg.
module pfd_value_ram (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pfd_pkg::t_val_wr            i_wr,
    input  logic [pfd_pkg::MAP_AW-1:0]  i_raddr,
    output logic [pfd_pkg::VALUE_W-1:0] o_rdata
);

    logic [pfd_pkg::VALUE_W-1:0]      r_mem [pfd_pkg::MAX_MAPPINGS];
    logic [pfd_pkg::MAX_MAPPINGS-1:0] r_vld;
    logic [pfd_pkg::VALUE_W-1:0]      r_rdata;
    logic                             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.value;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

@@ design/pdo_frame_demapper_core.sv @@
// Top level of the PDO frame demapper: request sequencer around the mapping
// table and value memories. Depends on pfd_pkg, pfd_map_ram, pfd_value_ram.
//
// A request is taken when start is high and busy is low. Clear and add
// requests finish without ever raising busy. Frame and query requests
// walk the mapping table one entry per cycle through the table's read port,
// visiting at most MAX_MAPPINGS entries with busy high; with an empty table
// they do not raise busy. Every request yields exactly one result, shown
// for a single cycle with o_valid high; the receiver cannot stall it, so
// capture it on that cycle. A new request may be issued in the same cycle
// a result is shown.
module pdo_frame_demapper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_object_index,
    input  logic [7:0]  i_sub_index,
    input  logic [5:0]  i_bit_length,
    input  logic [63:0] i_frame_data,
    input  logic [3:0]  i_frame_length,
    output logic        o_valid,
    output logic [31:0] o_value,
    output logic        o_found,
    output logic        o_accepted,
    output logic [3:0]  o_entries_updated
);

    localparam int AW = pfd_pkg::MAP_AW;
    localparam int CW = pfd_pkg::CNT_W;
    localparam int OW = pfd_pkg::OFFSET_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FRAME,
        S_QUERY
    } t_state;

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_upd, n_upd;
    logic [OW-1:0] r_off, n_off;
    logic [15:0] r_key_index, n_key_index;
    logic [7:0]  r_key_sub, n_key_sub;
    logic [63:0] r_data, n_data;
    logic [3:0]  r_flen, n_flen;
    logic        r_valid, n_valid;
    logic [31:0] r_value, n_value;
    logic        r_found, n_found;
    logic        r_accepted, n_accepted;
    logic [3:0]  r_updated, n_updated;

    pfd_pkg::t_map_wr    map_wr;
    pfd_pkg::t_val_wr    val_wr;
    pfd_pkg::t_map_entry map_rdata;
    logic [31:0]         val_rdata;
    logic [AW-1:0]       raddr;

    pfd_pkg::t_kind kind;
    logic        take;
    logic        last;
    logic [2:0]  nbytes;
    logic [3:0]  start_byte;
    logic        fits;
    logic [63:0] shifted;
    logic [31:0] extract;
    logic        match;

    assign kind = pfd_pkg::t_kind'(i_kind);
    assign take = start && (r_state == S_IDLE);
    assign busy = (r_state != S_IDLE);

    // Entry 0 is fetched at request time; afterwards prefetch the next entry.
    assign raddr = (r_state == S_IDLE) ? '0 : AW'(r_idx + AW'(1));

    assign last = ((CW'(r_idx) + CW'(1)) == r_count);

    // Frame extraction for the entry at the head of the walk
    assign nbytes     = map_rdata.bit_length[5:3];
    assign start_byte = r_off[OW-1:3];
    assign fits       = ({1'b0, start_byte} + {2'b00, nbytes}) <= {1'b0, r_flen};
    assign shifted    = r_data >> {start_byte, 3'b000};

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            extract[8*k +: 8] = (3'(k) < nbytes) ? shifted[8*k +: 8] : 8'h00;
        end
    end

    assign match = (map_rdata.object_index == r_key_index) &&
                   (map_rdata.sub_index == r_key_sub);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_upd       = r_upd;
        n_off       = r_off;
        n_key_index = r_key_index;
        n_key_sub   = r_key_sub;
        n_data      = r_data;
        n_flen      = r_flen;
        n_valid     = 1'b0;
        n_value     = '0;
        n_found     = 1'b0;
        n_accepted  = 1'b1;
        n_updated   = '0;
        map_wr      = '0;
        val_wr      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_key_index = i_object_index;
                    n_key_sub   = i_sub_index;
                    n_data      = i_frame_data;
                    n_flen      = (i_frame_length > 4'(pfd_pkg::FRAME_BYTES)) ?
                                  4'(pfd_pkg::FRAME_BYTES) : i_frame_length;
                    n_idx       = '0;
                    n_upd       = '0;
                    n_off       = '0;
                    unique case (kind)
                        pfd_pkg::KIND_CLEAR: begin
                            n_count = '0;
                            n_valid = 1'b1;
                        end
                        pfd_pkg::KIND_ADD: begin
                            n_valid = 1'b1;
                            if ((r_count < CW'(pfd_pkg::MAX_MAPPINGS)) &&
                                (i_bit_length <= 6'(pfd_pkg::MAX_BIT_LEN))) begin
                                map_wr.we    = 1'b1;
                                map_wr.addr  = AW'(r_count);
                                map_wr.entry = '{object_index: i_object_index,
                                                 sub_index:    i_sub_index,
                                                 bit_length:   i_bit_length};
                                n_count      = CW'(r_count + CW'(1));
                            end else begin
                                n_accepted = 1'b0;
                            end
                        end
                        pfd_pkg::KIND_FRAME: begin
                            if (r_count == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_state = S_FRAME;
                            end
                        end
                        pfd_pkg::KIND_QUERY: begin
                            if (r_count == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_state = S_QUERY;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_FRAME: begin
                if (fits) begin
                    val_wr.we    = 1'b1;
                    val_wr.addr  = r_idx;
                    val_wr.value = extract;
                    n_upd        = CW'(r_upd + CW'(1));
                    n_off        = OW'(r_off + OW'(map_rdata.bit_length));
                    n_idx        = AW'(r_idx + AW'(1));
                end
                // Stop at the first entry that does not fit, or after the last one.
                if (!fits || last) begin
                    n_state   = S_IDLE;
                    n_valid   = 1'b1;
                    n_updated = 4'(fits ? CW'(r_upd + CW'(1)) : r_upd);
                end
            end
            S_QUERY: begin
                n_idx = AW'(r_idx + AW'(1));
                if (match || last) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_found = match;
                    n_value = match ? val_rdata : '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_valid    <= 1'b0;
            r_idx      <= '0;
            r_upd      <= '0;
            r_off      <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_valid    <= n_valid;
            r_idx      <= n_idx;
            r_upd      <= n_upd;
            r_off      <= n_off;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_index <= n_key_index;
        r_key_sub   <= n_key_sub;
        r_data      <= n_data;
        r_flen      <= n_flen;
        r_value     <= n_value;
        r_found     <= n_found;
        r_accepted  <= n_accepted;
        r_updated   <= n_updated;
    end

    pfd_map_ram u_map_ram (
        .i_clk   (i_clk),
        .i_wr    (map_wr),
        .i_raddr (raddr),
        .o_rdata (map_rdata)
    );

    pfd_value_ram u_value_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (val_wr),
        .i_raddr (raddr),
        .o_rdata (val_rdata)
    );

    assign o_valid           = r_valid;
    assign o_value           = r_value;
    assign o_found           = r_found;
    assign o_accepted        = r_accepted;
    assign o_entries_updated = r_updated;

endmodule
